// ----- src/assert_macros.svh -----
// Assertion helpers shared by the angle position PID RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, quiet while reset is asserted.
`define APID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define APID_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APID_ASSERT(label, clk, rst_n, prop, msg)
`define APID_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- src/apid_pkg.sv -----
package apid_pkg;

    // field and register widths
    localparam int COUNT_W     = 14;
    localparam int GAIN_W      = 32;
    localparam int TARGET_W    = 20;
    localparam int ZERO_W      = 21;
    localparam int CUR_W       = 25;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // internal widths
    localparam int REL_W   = 20;             // angle within one turn
    localparam int DELTA_W = 22;             // angle minus zero, two and a half turns each way
    localparam int ERR_W   = 18;             // clamped error
    localparam int DIFF_W  = ERR_W + 1;      // error change
    localparam int PP_W    = GAIN_W + ERR_W;
    localparam int DP_W    = GAIN_W + DIFF_W;
    localparam int SUM_W   = DP_W + 1;
    localparam int PROD_SHIFT = 11;
    localparam int RND_W   = SUM_W - PROD_SHIFT;
    localparam int TOT_W   = RND_W + 1;
    localparam int LIMIT_W = 32;

    // one encoder count is 45 units of 1/2048 degree
    localparam logic [REL_W-1:0] UNITS_PER_COUNT = 20'd45;

    localparam logic signed [DELTA_W-1:0] FULL_TURN   = 22'sd737280;
    localparam logic signed [DELTA_W-1:0] DOUBLE_TURN = 22'sd1474560;
    localparam logic signed [DELTA_W-1:0] HALF_TURN   = 22'sd368640;
    localparam logic signed [DELTA_W-1:0] ERR_LIMIT   = 22'sd122880;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (PROD_SHIFT - 1);

    localparam logic signed [LIMIT_W-1:0] OUTPUT_LIMIT = 32'sd16777215;

    localparam logic signed [CUR_W-1:0] OUT_LOW_RESET  = 25'sh1000000;
    localparam logic signed [CUR_W-1:0] OUT_HIGH_RESET = 25'sh0FFFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_TARGET_ANGLE = 3'd3,
        CFG_ZERO_ANGLE   = 3'd4,
        CFG_DIRECTION    = 3'd5,
        CFG_OUT_LOW      = 3'd6,
        CFG_OUT_HIGH     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [TARGET_W-1:0]      target;
        logic signed [ZERO_W-1:0] zero;
        logic                     dir_neg;
    } angle_cfg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [CUR_W-1:0]  lo;
        logic signed [CUR_W-1:0]  hi;
    } pid_cfg_t;

endpackage

// ----- src/angle_position_pid_unit.sv -----
// Angle position PID unit: position loop of a motor driver.
// Input channel (in_valid / in_ready / encoder_count): one 14-bit absolute
// encoder count per control tick, one transaction per item.
// Output channel (out_valid / out_ready / current_ref): one signed current
// reference with 16 fraction bits for every input transaction, in order.
// Configuration: cfg_write / cfg_index / cfg_data write one register per
// cycle (gains, target, zero, direction, output limits); write only while
// no transaction is in flight.
// Throughput: one transaction per cycle while out_ready stays high; seven
// register stages (input, angle, modulo, error, products, integral,
// output) each hold one item.
// The integral and previous error state update in their own stage, so
// back-to-back items see each other's state in order.
// Stall: when out_ready is low the output holds; earlier stages keep
// filling empty slots and in_ready drops only once every stage is full.
// Reset: all stages empty, integral and previous error zero, gains zero,
// limits at full scale.
module angle_position_pid_unit
    import apid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COUNT_W-1:0]      encoder_count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [CUR_W-1:0] current_ref
);

    // configuration registers
    logic signed [GAIN_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [TARGET_W-1:0]      target_angle_reg;
    logic signed [ZERO_W-1:0] zero_angle_reg;
    logic                     direction_negative_reg;
    logic signed [CUR_W-1:0]  out_low_reg, out_high_reg;

    angle_cfg_t acfg;
    pid_cfg_t   pcfg;

    // error stage to PID stage channel
    logic                     err_valid, err_ready;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg          <= '0;
            integ_gain_reg         <= '0;
            deriv_gain_reg         <= '0;
            target_angle_reg       <= '0;
            zero_angle_reg         <= '0;
            direction_negative_reg <= 1'b0;
            out_low_reg            <= OUT_LOW_RESET;
            out_high_reg           <= OUT_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:    prop_gain_reg          <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:   integ_gain_reg         <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:   deriv_gain_reg         <= cfg_data[GAIN_W-1:0];
                CFG_TARGET_ANGLE: target_angle_reg       <= cfg_data[TARGET_W-1:0];
                CFG_ZERO_ANGLE:   zero_angle_reg         <= cfg_data[ZERO_W-1:0];
                CFG_DIRECTION:    direction_negative_reg <= cfg_data[0];
                CFG_OUT_LOW:      out_low_reg            <= cfg_data[CUR_W-1:0];
                CFG_OUT_HIGH:     out_high_reg           <= cfg_data[CUR_W-1:0];
                default:          ;
            endcase
        end
    end

    // bundle settings for each half of the datapath
    always_comb
    begin
        acfg.target  = target_angle_reg;
        acfg.zero    = zero_angle_reg;
        acfg.dir_neg = direction_negative_reg;
        pcfg.kp      = prop_gain_reg;
        pcfg.ki      = integ_gain_reg;
        pcfg.kd      = deriv_gain_reg;
        pcfg.lo      = out_low_reg;
        pcfg.hi      = out_high_reg;
    end

    // count -> wrapped, clamped error and its change since the last tick
    apid_err u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (acfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .count     (encoder_count),
        .err_valid (err_valid),
        .err_ready (err_ready),
        .err       (err),
        .diff      (diff)
    );

    // gains, integral with clamp, output sum with clamp
    apid_pid u_pid (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (pcfg),
        .in_valid    (err_valid),
        .in_ready    (err_ready),
        .err         (err),
        .diff        (diff),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .current_ref (current_ref)
    );

endmodule

// ----- src/apid_err.sv -----
`include "assert_macros.svh"

module apid_err
    import apid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  angle_cfg_t               cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COUNT_W-1:0]       count,
    output logic                     err_valid,
    input  logic                     err_ready,
    output logic signed [ERR_W-1:0]  err,
    output logic signed [DIFF_W-1:0] diff
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    logic load2, load3, load4;

    logic [COUNT_W-1:0]       count_reg;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic [REL_W-1:0]          rel_reg, rel_next;
    logic signed [ERR_W-1:0]   err_reg, err_next, prev_err_reg;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;

    logic [REL_W-1:0]          angle_mag;
    logic signed [ZERO_W-1:0]  angle_s;
    logic signed [DELTA_W-1:0] plus1, plus2, plus3, minus1, minus2, rel_sel;
    logic signed [DELTA_W-1:0] e0, e1, e2;

    // each stage takes a new transaction when empty or when its own moves on
    assign ready4 = !v4_reg || err_ready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign load2  = ready2 && v1_reg;
    assign load3  = ready3 && v2_reg;
    assign load4  = ready4 && v3_reg;

    assign in_ready  = ready1;
    assign err_valid = v4_reg;
    assign err       = err_reg;
    assign diff      = diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
            if (load4)
            begin
                prev_err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            count_reg <= count;
        end
        if (load2)
        begin
            delta_reg <= delta_next;
        end
        if (load3)
        begin
            rel_reg <= rel_next;
        end
        if (load4)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
    end

    // count to signed angle, minus zero
    always_comb
    begin
        angle_mag = REL_W'(count_reg) * UNITS_PER_COUNT;
        angle_s   = signed'(ZERO_W'(angle_mag));
        if (cfg.dir_neg)
        begin
            angle_s = -angle_s;
        end
        delta_next = DELTA_W'(angle_s) - DELTA_W'(cfg.zero);
    end

    // exact modulo one turn; delta lies within two and a half turns either way
    always_comb
    begin
        plus1  = delta_reg + FULL_TURN;
        plus2  = delta_reg + DOUBLE_TURN;
        plus3  = plus2 + FULL_TURN;
        minus1 = delta_reg - FULL_TURN;
        minus2 = delta_reg - DOUBLE_TURN;
        if (delta_reg < 0)
        begin
            rel_sel = (plus1 >= 0) ? plus1 : ((plus2 >= 0) ? plus2 : plus3);
        end
        else if (delta_reg >= FULL_TURN)
        begin
            rel_sel = (minus1 >= FULL_TURN) ? minus2 : minus1;
        end
        else
        begin
            rel_sel = delta_reg;
        end
        rel_next = rel_sel[REL_W-1:0];
    end

    // error: wrap once into half a turn, then clamp
    always_comb
    begin
        e0 = signed'(DELTA_W'(cfg.target)) - signed'(DELTA_W'(rel_reg));
        if (e0 > HALF_TURN)
        begin
            e1 = e0 - FULL_TURN;
        end
        else if (e0 < -HALF_TURN)
        begin
            e1 = e0 + FULL_TURN;
        end
        else
        begin
            e1 = e0;
        end
        if (e1 > ERR_LIMIT)
        begin
            e2 = ERR_LIMIT;
        end
        else if (e1 < -ERR_LIMIT)
        begin
            e2 = -ERR_LIMIT;
        end
        else
        begin
            e2 = e1;
        end
        err_next  = e2[ERR_W-1:0];
        diff_next = DIFF_W'(err_next) - DIFF_W'(prev_err_reg);
    end

    `APID_ASSERT(a_err_bounded, clk, rst_n, v4_reg |-> (err_reg <= ERR_LIMIT && err_reg >= -ERR_LIMIT), "clamped error out of range")
    `APID_ASSERT(a_rel_in_turn, clk, rst_n, v3_reg |-> (rel_reg < FULL_TURN[REL_W-1:0]), "relative angle not within one turn")
    `APID_ASSERT(a_prev_err_tracks, clk, rst_n, load4 |=> (prev_err_reg == err_reg), "previous error not updated with issued error")

endmodule

// ----- src/apid_pid.sv -----
`include "assert_macros.svh"

module apid_pid
    import apid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pid_cfg_t                 cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ERR_W-1:0]  err,
    input  logic signed [DIFF_W-1:0] diff,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CUR_W-1:0]  current_ref
);

    logic v5_reg, v6_reg, v7_reg;
    logic ready5, ready6, ready7;
    logic load6, load7;

    logic signed [PP_W-1:0]  pp_reg, pp_next, ip_reg, ip_next;
    logic signed [DP_W-1:0]  dp_reg, dp_next;
    logic signed [RND_W-1:0] pdr_reg, pdr_next;
    logic signed [CUR_W-1:0] intv_reg;
    logic signed [CUR_W-1:0] integ_reg, integ_next;
    logic signed [CUR_W-1:0] out_reg, out_next;

    logic signed [CUR_W-1:0] lo_eff, hi_eff;
    logic signed [SUM_W-1:0] ip_rnd, pd_rnd;
    logic signed [TOT_W-1:0] isum, tot;

    function automatic logic signed [CUR_W-1:0] clamp_cur(
        input logic signed [TOT_W-1:0] v,
        input logic signed [CUR_W-1:0] lo,
        input logic signed [CUR_W-1:0] hi
    );
        logic signed [CUR_W-1:0] r;
        if (v > TOT_W'(hi))
        begin
            r = hi;
        end
        else if (v < TOT_W'(lo))
        begin
            r = lo;
        end
        else
        begin
            r = v[CUR_W-1:0];
        end
        return r;
    endfunction

    // limits narrowed by the build-time output bound
    always_comb
    begin
        hi_eff = (LIMIT_W'(cfg.hi) < OUTPUT_LIMIT) ? cfg.hi : OUTPUT_LIMIT[CUR_W-1:0];
        lo_eff = (LIMIT_W'(cfg.lo) > -OUTPUT_LIMIT) ? cfg.lo : CUR_W'(-OUTPUT_LIMIT);
    end

    assign ready7 = !v7_reg || out_ready;
    assign ready6 = !v6_reg || ready7;
    assign ready5 = !v5_reg || ready6;
    assign load6  = ready6 && v5_reg;
    assign load7  = ready7 && v6_reg;

    assign in_ready    = ready5;
    assign out_valid   = v7_reg;
    assign current_ref = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            integ_reg <= '0;
        end
        else
        begin
            if (ready5)
            begin
                v5_reg <= in_valid;
            end
            if (ready6)
            begin
                v6_reg <= v5_reg;
            end
            if (ready7)
            begin
                v7_reg <= v6_reg;
            end
            if (load6)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready5 && in_valid)
        begin
            pp_reg <= pp_next;
            ip_reg <= ip_next;
            dp_reg <= dp_next;
        end
        if (load6)
        begin
            pdr_reg  <= pdr_next;
            intv_reg <= integ_next;
        end
        if (load7)
        begin
            out_reg <= out_next;
        end
    end

    // the three gain products, Q27
    always_comb
    begin
        pp_next = PP_W'(cfg.kp) * PP_W'(err);
        ip_next = PP_W'(cfg.ki) * PP_W'(err);
        dp_next = DP_W'(cfg.kd) * DP_W'(diff);
    end

    // integral update; integral has no fraction bits below Q16, so the
    // output rounding applies to kp and kd terms alone
    always_comb
    begin
        ip_rnd     = SUM_W'(ip_reg) + ROUND_HALF;
        isum       = TOT_W'(integ_reg) + TOT_W'(signed'(ip_rnd[SUM_W-1:PROD_SHIFT]));
        integ_next = clamp_cur(isum, lo_eff, hi_eff);
        pd_rnd     = SUM_W'(pp_reg) + SUM_W'(dp_reg) + ROUND_HALF;
        pdr_next   = pd_rnd[SUM_W-1:PROD_SHIFT];
    end

    always_comb
    begin
        tot      = TOT_W'(pdr_reg) + TOT_W'(intv_reg);
        out_next = clamp_cur(tot, lo_eff, hi_eff);
    end

    `APID_ASSERT(a_integ_in_limits, clk, rst_n, (load6 && lo_eff <= hi_eff) |=> (integ_reg <= $past(hi_eff) && integ_reg >= $past(lo_eff)), "integral outside limits")
    `APID_ASSERT(a_out_in_limits, clk, rst_n, (load7 && lo_eff <= hi_eff) |=> (out_reg <= $past(hi_eff) && out_reg >= $past(lo_eff)), "current reference outside limits")
    `APID_ASSERT_NR(a_reset_quiet, clk, !rst_n |-> (!out_valid && !v5_reg && !v6_reg), "pipeline not empty in reset")

endmodule
